>>> design/rptc_pkg.sv
// ----------------------------------------------------------------------------
// rptc_pkg
// Shared types and constants of the reconfiguration port transfer controller.
// ----------------------------------------------------------------------------
package rptc_pkg;

    // Number of reconfigurable regions with request / executing bits (1..4)
    localparam int NUM_REGIONS  = 4;
    localparam int REGION_W     = 2;
    localparam int MASK_W       = 4;
    localparam logic [MASK_W-1:0] REGION_MASK = MASK_W'((1 << NUM_REGIONS) - 1);

    // Field widths
    localparam int LEVEL_W      = 8;
    localparam int PHASE_W      = 3;
    localparam int TICKS_W      = 32;
    localparam int SPEED_W      = 10;
    localparam int BUS_W        = 8;
    localparam int SIZE_W       = 20;

    // Latency divide: size*8*port rate over port width*tick rate
    localparam int SIZE_SHIFT   = 3;
    localparam int NUM_W        = SIZE_W + SIZE_SHIFT + SPEED_W;
    localparam int DEN_W        = BUS_W + SPEED_W;
    localparam int DIV_STEPS    = NUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    // Stream payloads
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_FIELDS_W = 2 + MASK_W + LEVEL_W + REGION_W + PHASE_W + TICKS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = SIZE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SZ0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SZ1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SZ2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SZ3  = 3'd6;

    localparam logic [SPEED_W-1:0] RST_PORT_SPEED = 10'd100;
    localparam logic [BUS_W-1:0]   RST_PORT_WIDTH = 8'd32;
    localparam logic [SPEED_W-1:0] RST_TICK_RATE  = 10'd100;

    // Handshake phases
    localparam logic [PHASE_W-1:0] PH_INIT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ACK  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_XFER = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic tick;     // apply one item to the handshake state
        logic start;    // launch the latency divide
        logic finish;   // load the countdown and emit the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div; // the offered item loads the countdown
        logic div_done; // quotient ready
        logic out_free; // output register can take a result this cycle
    } t_sts;

endpackage

>>> design/rptc_div.sv
// ----------------------------------------------------------------------------
// rptc_div
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
module rptc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rptc_pkg::NUM_W-1:0]    i_num,
    input  logic [rptc_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [rptc_pkg::TICKS_W-1:0]  o_quot
);
    import rptc_pkg::*;

    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_W:0]       rem_sh;
    logic                 ge;
    logic [DEN_W:0]       diff;

    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    // zero divisor or quotient beyond 32 bits: saturate
    assign o_quot = ((r_den == '0) || (r_q[NUM_W-1:TICKS_W] != '0)) ? '1
                                                                     : r_q[TICKS_W-1:0];

endmodule

>>> design/rptc_datapath.sv
// ----------------------------------------------------------------------------
// rptc_datapath
// Configuration registers, handshake state, latency divide and result register.
// ----------------------------------------------------------------------------
module rptc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rptc_pkg::t_cmd                    i_cmd,
    output rptc_pkg::t_sts                    o_sts,
    input  logic [rptc_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_cfg_we,
    input  logic [rptc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rptc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rptc_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import rptc_pkg::*;

    // configuration; every region code has its own size register
    logic [SPEED_W-1:0]  r_port_speed;
    logic [BUS_W-1:0]    r_port_width;
    logic [SPEED_W-1:0]  r_tick_rate;
    logic [SIZE_W-1:0]   r_size [1 << REGION_W];

    // handshake state
    logic [PHASE_W-1:0]  r_phase,  n_phase;
    logic                r_ack,    n_ack;
    logic                r_xfer,   n_xfer;
    logic [MASK_W-1:0]   r_req,    n_req;
    logic [LEVEL_W-1:0]  r_level,  n_level;
    logic [REGION_W-1:0] r_region, n_region;
    logic [TICKS_W-1:0]  r_count,  n_count;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // latency operands
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_den;
    logic                div_done;
    logic [TICKS_W-1:0]  quot;

    // input fields
    logic                in_req;
    logic [REGION_W-1:0] in_sched;
    logic [LEVEL_W-1:0]  in_level;
    logic [MASK_W-1:0]   in_busy;
    logic                in_rack;
    logic [SIZE_W-1:0]   cur_size;

    assign in_req   = i_s_tdata[0];
    assign in_sched = i_s_tdata[2:1];
    assign in_level = i_s_tdata[10:3];
    assign in_busy  = i_s_tdata[14:11] & REGION_MASK;
    assign in_rack  = i_s_tdata[15];
    assign cur_size = r_size[r_region];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_speed <= RST_PORT_SPEED;
            r_port_width <= RST_PORT_WIDTH;
            r_tick_rate  <= RST_TICK_RATE;
            for (int k = 0; k < (1 << REGION_W); k++) begin
                r_size[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PORT_SPEED: r_port_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_PORT_WIDTH: r_port_width <= i_cfg_data[BUS_W-1:0];
                CFG_TICK_RATE:  r_tick_rate  <= i_cfg_data[SPEED_W-1:0];
                CFG_REGION_SZ0: r_size[0]    <= i_cfg_data;
                CFG_REGION_SZ1: r_size[1]    <= i_cfg_data;
                CFG_REGION_SZ2: r_size[2]    <= i_cfg_data;
                CFG_REGION_SZ3: r_size[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next handshake state for the offered item
    always_comb begin
        n_phase  = r_phase;
        n_ack    = r_ack && in_req;
        n_xfer   = r_xfer;
        n_req    = r_req;
        n_level  = r_level;
        n_region = r_region;
        n_count  = r_count;
        case (r_phase)
            PH_INIT: n_phase = PH_IDLE;
            PH_IDLE: begin
                if (in_req) begin
                    if (in_busy[r_region]) begin
                        n_ack   = 1'b1;
                        n_phase = PH_ACK;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            end
            PH_ACK: begin
                if (!in_req) begin
                    n_ack    = 1'b0;
                    n_level  = in_level;
                    n_region = in_sched;
                    n_req    = r_req | ((MASK_W'(1) << in_sched) & REGION_MASK);
                    n_xfer   = 1'b1;
                    n_phase  = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (in_rack) begin
                    n_req   = r_req & ~((MASK_W'(1) << r_region) & REGION_MASK);
                    n_phase = PH_XFER;
                end
            end
            PH_XFER: begin
                if (r_count == '0) begin
                    n_xfer  = 1'b0;
                    n_phase = PH_IDLE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: n_phase = PH_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_INIT;
            r_ack    <= 1'b0;
            r_xfer   <= 1'b0;
            r_req    <= '0;
            r_level  <= '0;
            r_region <= '0;
            r_count  <= '0;
        end else if (i_cmd.tick) begin
            r_phase  <= n_phase;
            r_ack    <= n_ack;
            r_xfer   <= n_xfer;
            r_req    <= n_req;
            r_level  <= n_level;
            r_region <= n_region;
            r_count  <= n_count;
        end else if (i_cmd.finish) begin
            r_count  <= quot;
        end
    end

    // latency operands, taken while the region is still the held one
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_num <= NUM_W'({cur_size, {SIZE_SHIFT{1'b0}}}) * NUM_W'(r_port_speed);
            r_den <= DEN_W'(r_port_width) * DEN_W'(r_tick_rate);
        end
    end

    rptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.tick && !o_sts.need_div) || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && !o_sts.need_div) begin
            r_out_data <= OUT_TDATA_W'({n_count, n_phase, n_region, n_level, n_req,
                                        n_xfer, n_ack});
        end else if (i_cmd.finish) begin
            r_out_data <= OUT_TDATA_W'({quot, r_phase, r_region, r_level, r_req,
                                        r_xfer, r_ack});
        end
    end

    assign o_sts.need_div = (r_phase == PH_WAIT) && in_rack;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> design/rptc_ctrl.sv
// ----------------------------------------------------------------------------
// rptc_ctrl
// Sequencer: takes items, runs the latency divide when one is due.
// ----------------------------------------------------------------------------
module rptc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  rptc_pkg::t_sts i_sts,
    output rptc_pkg::t_cmd o_cmd
);
    import rptc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;

    logic [1:0] r_state, n_state;
    logic       accept;

    assign o_s_tready = (r_state == ST_IDLE) && i_sts.out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state      = r_state;
        o_cmd.tick   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.tick = 1'b1;
                    if (i_sts.need_div) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/reconfig_port_transfer_controller_core.sv
// ----------------------------------------------------------------------------
// reconfig_port_transfer_controller_core
// Request/acknowledge controller for a reconfiguration port transfer.
// ----------------------------------------------------------------------------
// Each input item is one tick of a five-phase handshake (init, idle, ack,
// wait, transfer); each item yields exactly one result item showing the state
// after that tick. A tick is taken in a cycle when the sequencer is idle and
// the output register is free; unless it loads the countdown, its result
// appears on the next cycle. The item that sees the region acknowledge in wait
// loads the transfer countdown with size*8*port_speed / (port data width *
// sim_clock_speed), saturated to 32 bits; that quotient comes from a restoring
// divider producing one bit per cycle after a start step, and the input is
// held off from acceptance of such an item until the quotient is loaded into
// the countdown and the result register. Configuration writes are always ready
// and are registered; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module reconfig_port_transfer_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item: [0] ctrl_request, [2:1] scheduled_region, [10:3] source_level,
    // [14:11] region_busy_mask, [15] region_ack
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rptc_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // result item: [0] ctrl_ack, [1] busy_transferring, [5:2] region_request_mask,
    // [13:6] latched_level, [15:14] latched_region, [18:16] phase,
    // [50:19] ticks_left, [55:51] zero
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rptc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rptc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rptc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rptc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // registers are plain flops: take every write at once
    assign o_cfg_ready = 1'b1;

    rptc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rptc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

>>> dv/rptc_tick_checker.sv
// ----------------------------------------------------------------------------
// rptc_tick_checker
// Watches the tick, result and register-write channels of the transfer
// controller, predicts the state after every accepted tick and compares it,
// field by field, with the result items in order.
// ----------------------------------------------------------------------------
module rptc_tick_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [rptc_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [rptc_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [rptc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rptc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_pending,
    output int                                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import rptc_pkg::*;

    localparam int REPORT_LIMIT = 25;

    // Result fields, lowest bit last in the list
    typedef struct packed {
        logic [TICKS_W-1:0]  ticks_left;
        logic [PHASE_W-1:0]  phase;
        logic [REGION_W-1:0] region;
        logic [LEVEL_W-1:0]  level;
        logic [MASK_W-1:0]   request_mask;
        logic                transferring;
        logic                ack;
    } t_tick_status;

    // Register shadow
    logic [SPEED_W-1:0] port_speed_r = RST_PORT_SPEED;
    logic [BUS_W-1:0]   port_width_r = RST_PORT_WIDTH;
    logic [SPEED_W-1:0] tick_rate_r  = RST_TICK_RATE;
    logic [SIZE_W-1:0]  region_size_r [4] = '{default: '0};

    // Handshake state
    logic [PHASE_W-1:0]  hs_phase      = PH_INIT;
    logic                hs_ack        = 1'b0;
    logic                hs_transfer   = 1'b0;
    logic [MASK_W-1:0]   hs_requests   = '0;
    logic [LEVEL_W-1:0]  hs_level      = '0;
    logic [REGION_W-1:0] hs_region     = '0;
    logic [TICKS_W-1:0]  hs_countdown  = '0;

    t_tick_status expected_status_q [$];
    int           mismatch_total  = 0;
    int           results_checked = 0;

    // floor(size*8*port rate / (port width*tick rate)), saturated to 32 bits
    function automatic logic [TICKS_W-1:0] transfer_latency(
        input logic [REGION_W-1:0] region);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = 64'(region_size_r[region]) * 64'd8 * 64'(port_speed_r);
        den = 64'(port_width_r) * 64'(tick_rate_r);
        if (den == 64'd0) return '1;
        quo = num / den;
        if (quo > 64'hFFFF_FFFF) return '1;
        return quo[TICKS_W-1:0];
    endfunction

    // Apply one tick to the handshake state and return the state after it
    function automatic t_tick_status advance_handshake(input logic [IN_TDATA_W-1:0] tick);
        logic                req;
        logic [REGION_W-1:0] sched;
        logic [LEVEL_W-1:0]  level;
        logic [MASK_W-1:0]   busy;
        logic                rack;
        t_tick_status        st;
        req   = tick[0];
        sched = tick[2:1];
        level = tick[10:3];
        busy  = tick[14:11] & REGION_MASK;
        rack  = tick[15];

        if (hs_ack && !req) hs_ack = 1'b0;

        case (hs_phase)
            PH_INIT: hs_phase = PH_IDLE;
            PH_IDLE: begin
                if (req) begin
                    if (busy[hs_region]) begin
                        hs_ack   = 1'b1;
                        hs_phase = PH_ACK;
                    end else begin
                        hs_phase = PH_WAIT;
                    end
                end
            end
            PH_ACK: begin
                if (!req) begin
                    hs_ack      = 1'b0;
                    hs_level    = level;
                    hs_region   = sched;
                    hs_requests = hs_requests | ((MASK_W'(1) << sched) & REGION_MASK);
                    hs_transfer = 1'b1;
                    hs_phase    = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (rack) begin
                    hs_requests  = hs_requests & ~((MASK_W'(1) << hs_region) & REGION_MASK);
                    hs_countdown = transfer_latency(hs_region);
                    hs_phase     = PH_XFER;
                end
            end
            PH_XFER: begin
                if (hs_countdown == '0) begin
                    hs_transfer = 1'b0;
                    hs_phase    = PH_IDLE;
                end else begin
                    hs_countdown = hs_countdown - 1'b1;
                end
            end
            default: hs_phase = PH_INIT;
        endcase

        st.ack          = hs_ack;
        st.transferring = hs_transfer;
        st.request_mask = hs_requests;
        st.level        = hs_level;
        st.region       = hs_region;
        st.phase        = hs_phase;
        st.ticks_left   = hs_countdown;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT)
            $display("result %0d: %s is %0h, expected %0h", results_checked, what, got, want);
    endtask

    task automatic check_status(input logic [OUT_TDATA_W-1:0] word, input t_tick_status want);
        t_tick_status got;
        got = word[OUT_FIELDS_W-1:0];
        if (got.ack !== want.ack)
            report_mismatch("ctrl_ack", 64'(got.ack), 64'(want.ack));
        if (got.transferring !== want.transferring)
            report_mismatch("busy_transferring", 64'(got.transferring), 64'(want.transferring));
        if (got.request_mask !== want.request_mask)
            report_mismatch("region_request_mask", 64'(got.request_mask),
                            64'(want.request_mask));
        if (got.level !== want.level)
            report_mismatch("latched_level", 64'(got.level), 64'(want.level));
        if (got.region !== want.region)
            report_mismatch("latched_region", 64'(got.region), 64'(want.region));
        if (got.phase !== want.phase)
            report_mismatch("phase", 64'(got.phase), 64'(want.phase));
        if (got.ticks_left !== want.ticks_left)
            report_mismatch("ticks_left", 64'(got.ticks_left), 64'(want.ticks_left));
        if (word[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
            report_mismatch("padding", 64'(word[OUT_TDATA_W-1:OUT_FIELDS_W]), 64'd0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            port_speed_r = RST_PORT_SPEED;
            port_width_r = RST_PORT_WIDTH;
            tick_rate_r  = RST_TICK_RATE;
            foreach (region_size_r[r]) region_size_r[r] = '0;
            hs_phase     = PH_INIT;
            hs_ack       = 1'b0;
            hs_transfer  = 1'b0;
            hs_requests  = '0;
            hs_level     = '0;
            hs_region    = '0;
            hs_countdown = '0;
            expected_status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PORT_SPEED: port_speed_r     = i_cfg_data[SPEED_W-1:0];
                    CFG_PORT_WIDTH: port_width_r     = i_cfg_data[BUS_W-1:0];
                    CFG_TICK_RATE:  tick_rate_r      = i_cfg_data[SPEED_W-1:0];
                    CFG_REGION_SZ0: region_size_r[0] = i_cfg_data;
                    CFG_REGION_SZ1: region_size_r[1] = i_cfg_data;
                    CFG_REGION_SZ2: region_size_r[2] = i_cfg_data;
                    CFG_REGION_SZ3: region_size_r[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_status_q.insert(expected_status_q.size(),
                                         advance_handshake(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_status_q.size() == 0)
                    report_mismatch("result with no tick waiting", 64'(i_m_tdata), 64'd0);
                else
                    check_status(i_m_tdata, expected_status_q.pop_front());
                results_checked++;
            end
        end
        o_pending    <= expected_status_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

>>> dv/tb_reconfig_port_transfer_controller_core.sv
// ----------------------------------------------------------------------------
// tb_reconfig_port_transfer_controller_core
// Stimulus and verdict for the reconfiguration port transfer controller.
// ----------------------------------------------------------------------------
// A short directed walk through every handshake phase at the reset register
// values is followed by phases of request/acknowledge cycles with random
// content under several register settings (speed and width extremes, large
// region sizes) and different amounts of source gaps and sink stalls. The
// run closes with a saturated transfer latency. A separate checker predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module tb_reconfig_port_transfer_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rptc_pkg::*;

    // Largest countdown aimed for in the regular phases, so transfers finish
    localparam int MAX_LAT         = 40;
    localparam int TICKS_PER_PHASE = 320;
    localparam int FINAL_TICKS     = 40;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_s_tvalid  = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    int    ticks_pending;
    int    mismatch_count;
    int    src_gap_pct      = 0;
    int    sink_stall_pct   = 0;
    int    hold_off_request = 0;
    int    ticks_sent       = 0;
    int    settings_used    = 0;
    string saturation_case  = "";

    reconfig_port_transfer_controller_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rptc_tick_checker u_tick_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (ticks_pending),
        .o_fail_count (mismatch_count)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("tb_reconfig_port_transfer_controller_core NOT OK");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request so the
    // block backs up into its input
    initial begin : sink_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request != 0) begin
                hold_left        = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
            end
        end
    end

    // Pack one tick, lowest field first
    function automatic logic [IN_TDATA_W-1:0] make_tick(input logic req,
                                                        input logic [REGION_W-1:0] region,
                                                        input logic [LEVEL_W-1:0] level,
                                                        input logic [MASK_W-1:0] busy,
                                                        input logic rack);
        return {rack, busy, level, region, req};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_tick();
        return make_tick(1'($urandom), 2'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
    endfunction

    // Largest region size whose latency stays within MAX_LAT
    function automatic logic [SIZE_W-1:0] size_cap_for(input logic [SPEED_W-1:0] port,
                                                       input logic [BUS_W-1:0] bus,
                                                       input logic [SPEED_W-1:0] sim);
        logic [63:0] cap;
        cap = (64'(MAX_LAT) * 64'(bus) * 64'(sim)) / (64'd8 * 64'(port));
        if (cap > 64'(20'hFFFFF)) cap = 64'(20'hFFFFF);
        return cap[SIZE_W-1:0];
    endfunction

    // Offer one tick, with random gaps ahead of it; hold valid for the next one
    task automatic send_item(input logic [IN_TDATA_W-1:0] tick);
        while ($urandom_range(99, 0) < src_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= tick;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Wait until every result item has come back
    task automatic wait_drained();
        do @(posedge i_clk); while (ticks_pending != 0);
    endtask

    // One request/acknowledge round with random content: request low for a
    // while, request raised (mostly with all executing bits set so the ack
    // path runs), request dropped, region acknowledge, then countdown ticks
    task automatic send_transfer_round(input int tail_max);
        logic [MASK_W-1:0] busy;
        repeat ($urandom_range(2, 0))
            send_item(make_tick(1'b0, 2'($urandom), 8'($urandom), 4'($urandom), 1'($urandom)));
        repeat ($urandom_range(3, 1)) begin
            busy = ($urandom_range(3, 0) != 0) ? 4'hF : 4'($urandom);
            send_item(make_tick(1'b1, 2'($urandom), 8'($urandom), busy, 1'($urandom)));
        end
        repeat ($urandom_range(2, 1))
            send_item(make_tick(1'b0, 2'($urandom), 8'($urandom), 4'($urandom), 1'b0));
        repeat ($urandom_range(3, 0))
            send_item(make_tick(1'($urandom), 2'($urandom), 8'($urandom), 4'($urandom), 1'b0));
        send_item(make_tick(1'($urandom), 2'($urandom), 8'($urandom), 4'($urandom), 1'b1));
        repeat ($urandom_range(tail_max + 2, 0)) send_item(random_tick());
    endtask

    // Drain, load a register setting, then stream rounds and some noise
    task automatic run_phase(input logic [SPEED_W-1:0] port, input logic [BUS_W-1:0] bus,
                             input logic [SPEED_W-1:0] sim, input logic [SIZE_W-1:0] size_cap,
                             input int n_ticks, input int src_pct, input int sink_pct,
                             input int hold_cycles);
        logic [SIZE_W-1:0] sizes [4];
        int                first;
        wait_drained();
        src_gap_pct    = src_pct;
        sink_stall_pct = sink_pct;
        for (int r = 0; r < 3; r++) sizes[r] = SIZE_W'($urandom_range(size_cap, 0));
        sizes[3] = size_cap;
        // Junk above each narrow register must be dropped by the block
        cfg_write(CFG_PORT_SPEED, {10'($urandom), port});
        cfg_write(CFG_PORT_WIDTH, {12'($urandom), bus});
        cfg_write(CFG_TICK_RATE,  {10'($urandom), sim});
        cfg_write(CFG_REGION_SZ0, sizes[0]);
        cfg_write(CFG_REGION_SZ1, sizes[1]);
        cfg_write(CFG_REGION_SZ2, sizes[2]);
        cfg_write(CFG_REGION_SZ3, sizes[3]);
        i_cfg_valid <= 1'b0;
        settings_used++;
        hold_off_request = hold_cycles;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks) begin
            if ($urandom_range(4, 0) != 0)
                send_transfer_round(MAX_LAT);
            else
                repeat ($urandom_range(4, 1)) send_item(random_tick());
        end
        i_s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [SPEED_W-1:0] port;
        logic [BUS_W-1:0]   bus;
        logic [SPEED_W-1:0] sim;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk at the reset register values (all sizes zero, so
        // every countdown is zero)
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b0));     // init to idle
        send_item(make_tick(1'b1, 2'd0, 8'd0, 4'h1, 1'b0));     // region 0 executing: ack
        send_item(make_tick(1'b1, 2'd0, 8'd0, 4'h0, 1'b0));     // request held: stay in ack
        send_item(make_tick(1'b0, 2'd3, 8'hFF, 4'h0, 1'b0));    // release: latch region 3
        send_item(make_tick(1'b1, 2'd0, 8'd0, 4'hF, 1'b0));     // wait, no region ack
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b1));     // region ack: countdown
        send_item(make_tick(1'b1, 2'd1, 8'd0, 4'hF, 1'b1));     // zero count: back to idle
        send_item(make_tick(1'b1, 2'd0, 8'd0, 4'h7, 1'b0));     // region 3 not executing
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b1));     // region ack in wait
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b0));     // to idle
        send_item(make_tick(1'b1, 2'd0, 8'd0, 4'h8, 1'b0));     // region 3 executing: ack
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'hF, 1'b1));     // release, region ack ignored
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b1));     // region ack
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b0));     // to idle
        send_item(make_tick(1'b0, 2'd3, 8'hFF, 4'hF, 1'b1));    // idle, no request: stay
        send_item(make_tick(1'b1, 2'd0, 8'd0, 4'h1, 1'b0));     // ack
        send_item(make_tick(1'b0, 2'd1, 8'hA5, 4'h0, 1'b0));    // latch region 1
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b1));
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b0));
        send_item(make_tick(1'b1, 2'd0, 8'd0, 4'h2, 1'b0));     // ack
        send_item(make_tick(1'b0, 2'd2, 8'h5A, 4'h0, 1'b0));    // latch region 2
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b1));
        send_item(make_tick(1'b0, 2'd0, 8'd0, 4'h0, 1'b0));
        i_s_tvalid <= 1'b0;

        // Reset-like speeds, no idling, long sink hold-off up front
        run_phase(10'd100, 8'd32, 10'd100, size_cap_for(10'd100, 8'd32, 10'd100),
                  TICKS_PER_PHASE, 0, 0, HOLD_OFF_CYCLES);
        // Fastest port, narrowest bus, slowest tick: zero-size regions only
        run_phase(10'd1023, 8'd8, 10'd1, size_cap_for(10'd1023, 8'd8, 10'd1),
                  TICKS_PER_PHASE, 75, 0, 0);
        // Slowest port, widest bus, fastest tick: full 20-bit sizes
        run_phase(10'd1, 8'd255, 10'd1023, size_cap_for(10'd1, 8'd255, 10'd1023),
                  TICKS_PER_PHASE, 0, 75, 0);
        // Random settings, first under both kinds of idling, then with a long sink hold-off
        port = 10'($urandom_range(1023, 1));
        bus  = 8'($urandom_range(255, 1));
        sim  = 10'($urandom_range(1023, 1));
        run_phase(port, bus, sim, size_cap_for(port, bus, sim), TICKS_PER_PHASE, 28, 28, 0);
        port = 10'($urandom_range(1023, 1));
        bus  = 8'($urandom_range(255, 1));
        sim  = 10'($urandom_range(1023, 1));
        run_phase(port, bus, sim, size_cap_for(port, bus, sim), TICKS_PER_PHASE, 0, 0,
                  HOLD_OFF_CYCLES);

        // Saturated latency last: once loaded, the countdown does not run out within these ticks
        case ($urandom_range(2, 0))
            0: begin
                saturation_case = "zero bus width";
                run_phase(10'($urandom_range(1023, 1)), 8'd0, 10'($urandom_range(1023, 1)),
                          20'($urandom), FINAL_TICKS, 0, 0, 0);
            end
            1: begin
                saturation_case = "zero tick rate";
                run_phase(10'($urandom_range(1023, 1)), 8'($urandom_range(255, 1)), 10'd0,
                          20'($urandom), FINAL_TICKS, 0, 0, 0);
            end
            default: begin
                saturation_case = "quotient above 32 bits";
                run_phase(10'd1023, 8'd1, 10'd1, 20'hFFFFF, FINAL_TICKS, 0, 0, 0);
            end
        endcase

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d ticks over %0d register settings plus the reset values,",
                 ticks_sent, settings_used);
        $display("with source gaps, sink stalls, sink hold-offs and a %s latency",
                 saturation_case);
        if (mismatch_count == 0 && ticks_pending == 0) begin
            $display("tb_reconfig_port_transfer_controller_core OK");
        end else begin
            $display("tb_reconfig_port_transfer_controller_core NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
design/rptc_pkg.sv
design/rptc_div.sv
design/rptc_datapath.sv
design/rptc_ctrl.sv
design/reconfig_port_transfer_controller_core.sv
dv/rptc_tick_checker.sv
dv/tb_reconfig_port_transfer_controller_core.sv
